[rtl/core/base64_stream_encoder_core_defines.svh]
// ----------------------------------------------------------------------------
// base64 stream encoder assertion macros
// clocked property checks shared by the encoder modules
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_ENCODER_CORE_DEFINES_SVH
`define BASE64_STREAM_ENCODER_CORE_DEFINES_SVH

// check with reset masking
`define B64E_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that also holds while reset is applied
`define B64E_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[rtl/core/b64enc_pkg.sv]
// ----------------------------------------------------------------------------
// b64enc_pkg
// types, constants and the character table of the base64 stream encoder
// ----------------------------------------------------------------------------
package b64enc_pkg;

  localparam int ByteW         = 8;
  localparam int SextetW       = 6;
  localparam int GroupW        = 24;
  localparam int PendW         = 16;
  localparam int CntW          = 2;
  localparam int NCharsW       = 3;
  localparam int IdxW          = 2;
  localparam int QueueDepth    = 2;
  localparam int QueuePtrW     = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QueueCntW     = $clog2(QueueDepth + 1);

  localparam logic [ByteW-1:0]   PadChar   = 8'h3D;
  localparam logic [CntW-1:0]    CntEmpty  = 2'd0;
  localparam logic [CntW-1:0]    CntOne    = 2'd1;
  localparam logic [CntW-1:0]    CntTwo    = 2'd2;
  localparam logic [NCharsW-1:0] NCharsOne = 3'd2;
  localparam logic [NCharsW-1:0] NCharsTwo = 3'd3;
  localparam logic [NCharsW-1:0] NCharsAll = 3'd4;
  localparam logic [IdxW-1:0]    IdxLast   = 2'd3;

  typedef struct packed {
    logic [GroupW-1:0]  group;
    logic [NCharsW-1:0] nchars;
    logic               last;
  } b64enc_group_t;

  typedef struct packed {
    logic          valid;
    b64enc_group_t entry;
  } b64enc_qwr_t;

  typedef struct packed {
    logic          valid;
    b64enc_group_t entry;
  } b64enc_qrd_t;

  function automatic logic [ByteW-1:0] b64_char(input logic [SextetW-1:0] v);
    logic [ByteW-1:0] ext;
    logic [ByteW-1:0] ch;
    ext = {2'b00, v};
    case (v) inside
      [6'd0:6'd25]:  ch = ext + 8'd65;
      [6'd26:6'd51]: ch = ext + 8'd71;
      [6'd52:6'd61]: ch = ext - 8'd4;
      6'd62:         ch = 8'h2B;
      6'd63:         ch = 8'h2F;
      default:       ch = PadChar;
    endcase
    return ch;
  endfunction

endpackage

[rtl/core/b64enc_if.sv]
// ----------------------------------------------------------------------------
// b64enc_if
// valid/ready channels for raw bytes in and encoded characters out
// ----------------------------------------------------------------------------
interface b64enc_byte_if;
  logic                          valid;
  logic                          ready;
  logic [b64enc_pkg::ByteW-1:0]  data_byte;
  logic                          end_of_message;

  modport source (output valid, output data_byte, output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface b64enc_char_if;
  logic                          valid;
  logic                          ready;
  logic [b64enc_pkg::ByteW-1:0]  out_char;
  logic                          final_char;

  modport source (output valid, output out_char, output final_char, input ready);
  modport sink   (input valid, input out_char, input final_char, output ready);
endinterface

[rtl/core/b64enc_front.sv]
// ----------------------------------------------------------------------------
// b64enc_front
// takes raw bytes, gathers them into groups and queues finished groups
// ----------------------------------------------------------------------------
module b64enc_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  b64enc_byte_if.sink               msg_i,
  input  logic                      full_i,
  output b64enc_pkg::b64enc_qwr_t   wr_o
);

  logic [b64enc_pkg::PendW-1:0] pending_bytes_q, pending_bytes_d;
  logic [b64enc_pkg::CntW-1:0]  pending_count_q, pending_count_d;
  logic                         accept;

  assign msg_i.ready = !full_i;
  assign accept      = msg_i.valid && !full_i;

  always_comb begin
    pending_bytes_d = pending_bytes_q;
    pending_count_d = pending_count_q;
    wr_o            = '0;
    if (accept) begin
      if (pending_count_q >= b64enc_pkg::CntTwo) begin
        wr_o.valid        = 1'b1;
        wr_o.entry.group  = {pending_bytes_q, msg_i.data_byte};
        wr_o.entry.nchars = b64enc_pkg::NCharsAll;
        wr_o.entry.last   = msg_i.end_of_message;
        pending_bytes_d   = '0;
        pending_count_d   = b64enc_pkg::CntEmpty;
      end else if (!msg_i.end_of_message) begin
        if (pending_count_q == b64enc_pkg::CntEmpty) begin
          pending_bytes_d = {msg_i.data_byte, 8'h00};
        end else begin
          pending_bytes_d = {pending_bytes_q[15:8], msg_i.data_byte};
        end
        pending_count_d = pending_count_q + b64enc_pkg::CntOne;
      end else begin
        wr_o.valid      = 1'b1;
        wr_o.entry.last = 1'b1;
        if (pending_count_q == b64enc_pkg::CntEmpty) begin
          wr_o.entry.group  = {msg_i.data_byte, 16'h0000};
          wr_o.entry.nchars = b64enc_pkg::NCharsOne;
        end else begin
          wr_o.entry.group  = {pending_bytes_q[15:8], msg_i.data_byte, 8'h00};
          wr_o.entry.nchars = b64enc_pkg::NCharsTwo;
        end
        pending_bytes_d = '0;
        pending_count_d = b64enc_pkg::CntEmpty;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_bytes_q <= '0;
      pending_count_q <= b64enc_pkg::CntEmpty;
    end else begin
      pending_bytes_q <= pending_bytes_d;
      pending_count_q <= pending_count_d;
    end
  end

endmodule

[rtl/core/b64enc_queue.sv]
// ----------------------------------------------------------------------------
// b64enc_queue
// short queue of finished groups between front and back
// ----------------------------------------------------------------------------
`include "base64_stream_encoder_core_defines.svh"

module b64enc_queue (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  b64enc_pkg::b64enc_qwr_t   wr_i,
  output logic                      full_o,
  output b64enc_pkg::b64enc_qrd_t   rd_o,
  input  logic                      pop_i
);

  b64enc_pkg::b64enc_group_t              mem_q [b64enc_pkg::QueueDepth];
  logic [b64enc_pkg::QueuePtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [b64enc_pkg::QueuePtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [b64enc_pkg::QueueCntW-1:0]       cnt_q, cnt_d;

  localparam logic [b64enc_pkg::QueuePtrW-1:0] PtrLast =
    b64enc_pkg::QueuePtrW'(b64enc_pkg::QueueDepth - 1);
  localparam logic [b64enc_pkg::QueueCntW-1:0] CntFull =
    b64enc_pkg::QueueCntW'(b64enc_pkg::QueueDepth);

  assign full_o     = (cnt_q == CntFull);
  assign rd_o.valid = (cnt_q != '0);
  assign rd_o.entry = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_i.valid) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({wr_i.valid, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.valid) begin
      mem_q[wr_ptr_q] <= wr_i.entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  `B64E_ASSERT(a_no_overflow, wr_i.valid |-> !full_o, "group pushed into a full queue")
  `B64E_ASSERT(a_no_underflow, pop_i |-> (cnt_q != '0), "group popped from an empty queue")
  `B64E_ASSERT_ALWAYS(a_cnt_range, cnt_q <= CntFull, "queue fill count out of range")

endmodule

[rtl/core/b64enc_back.sv]
// ----------------------------------------------------------------------------
// b64enc_back
// turns queued groups into characters, one per cycle while the receiver is ready, into an output register
`include "base64_stream_encoder_core_defines.svh"

module b64enc_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  b64enc_pkg::b64enc_qrd_t   rd_i,
  output logic                      pop_o,
  b64enc_char_if.source             enc_o
);

  b64enc_pkg::b64enc_group_t        cur_q, cur_d;
  logic                             busy_q, busy_d;
  logic [b64enc_pkg::IdxW-1:0]      idx_q, idx_d;
  logic                             out_valid_q, out_valid_d;
  logic [b64enc_pkg::ByteW-1:0]     out_char_q, out_char_d;
  logic                             out_final_q, out_final_d;

  b64enc_pkg::b64enc_group_t        src;
  logic [b64enc_pkg::IdxW-1:0]      k;
  logic [b64enc_pkg::SextetW-1:0]   sextet;
  logic                             have;
  logic                             adv;

  assign src  = busy_q ? cur_q : rd_i.entry;
  assign k    = busy_q ? idx_q : '0;
  assign have = busy_q || rd_i.valid;
  assign adv  = have && (!out_valid_q || enc_o.ready);
  assign pop_o = adv && !busy_q;

  always_comb begin
    case (k)
      2'd0:    sextet = src.group[23:18];
      2'd1:    sextet = src.group[17:12];
      2'd2:    sextet = src.group[11:6];
      default: sextet = src.group[5:0];
    endcase
  end

  always_comb begin
    cur_d       = cur_q;
    busy_d      = busy_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_final_d = out_final_q;
    if (adv) begin
      out_valid_d = 1'b1;
      out_char_d  = ({1'b0, k} < src.nchars) ? b64enc_pkg::b64_char(sextet)
                                             : b64enc_pkg::PadChar;
      out_final_d = src.last && (k == b64enc_pkg::IdxLast);
      if (k == b64enc_pkg::IdxLast) begin
        busy_d = 1'b0;
        idx_d  = '0;
      end else begin
        busy_d = 1'b1;
        cur_d  = src;
        idx_d  = k + 1'b1;
      end
    end else if (enc_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    out_char_q <= out_char_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      out_final_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      out_final_q <= out_final_d;
    end
  end

  assign enc_o.valid      = out_valid_q;
  assign enc_o.out_char   = out_char_q;
  assign enc_o.final_char = out_final_q;

  `B64E_ASSERT(a_idle_idx, !busy_q |-> (idx_q == '0), "character index not cleared when idle")
  `B64E_ASSERT(a_final_ends_group, (out_valid_q && out_final_q) |-> !busy_q,
               "group still in progress behind the final character")

endmodule

[rtl/core/base64_stream_encoder_core.sv]
// ----------------------------------------------------------------------------
// base64_stream_encoder_core: closed groups pass a group queue, then an output register
// throughput one char per cycle while the receiver is ready, set by the output stage
// up to one byte per cycle while the two-entry group queue has room
// asynchronous active-low reset clears pending bytes, queue and the valid and final flags of the output register
// ----------------------------------------------------------------------------
module base64_stream_encoder_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  b64enc_byte_if.sink    msg_i,
  b64enc_char_if.source  enc_o
);

  b64enc_pkg::b64enc_qwr_t  q_wr;
  b64enc_pkg::b64enc_qrd_t  q_rd;
  logic                     q_full;
  logic                     q_pop;

  b64enc_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .msg_i  (msg_i),
    .full_i (q_full),
    .wr_o   (q_wr)
  );

  b64enc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (q_wr),
    .full_o (q_full),
    .rd_o   (q_rd),
    .pop_i  (q_pop)
  );

  b64enc_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rd_i   (q_rd),
    .pop_o  (q_pop),
    .enc_o  (enc_o)
  );

endmodule

[tb/tb_base64_stream_encoder_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_base64_stream_encoder_core
// directed table then random messages with random idling on both channels,
// every char checked against the table or a base64 predictor, one long
// receiver hold so the encoder fills up and stalls its input
// ----------------------------------------------------------------------------
module tb_base64_stream_encoder_core;

  localparam int NumItems   = 230;
  localparam int MaxGap     = 13;
  localparam int HoldCycles = 150;
  localparam int DirRows    = 20;
  localparam int DrainCyc   = 20;

  typedef struct packed {
    logic [b64enc_pkg::ByteW-1:0] data;
    logic                         eom;
    logic                         typed;
    logic [31:0]                  chars;
  } dir_row_t;

  typedef struct packed {
    logic [b64enc_pkg::ByteW-1:0] ch;
    logic                         fin;
  } enc_char_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  b64enc_byte_if msg_if ();
  b64enc_char_if enc_if ();

  base64_stream_encoder_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .msg_i  (msg_if),
    .enc_o  (enc_if)
  );

  always #5 clk_i = ~clk_i;

  string alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // predictor state
  logic [b64enc_pkg::PendW-1:0] pend_bytes;
  logic [b64enc_pkg::CntW-1:0]  pend_cnt;

  enc_char_t char_q[$];
  int        err_cnt  = 0;
  int        sent_cnt = 0;
  bit        tx_idle  = 1'b1;
  bit        rx_idle  = 1'b1;
  bit        hold_req = 1'b0;

  dir_row_t dir_tab [DirRows] = '{
    '{8'h00, 1'b1, 1'b1, "AA=="},
    '{8'hFF, 1'b1, 1'b1, "/w=="},
    '{8'h00, 1'b0, 1'b0, 32'h0},
    '{8'h00, 1'b1, 1'b1, "AAA="},
    '{8'hFF, 1'b0, 1'b0, 32'h0},
    '{8'hFF, 1'b1, 1'b1, "//8="},
    '{8'h00, 1'b0, 1'b0, 32'h0},
    '{8'h00, 1'b0, 1'b0, 32'h0},
    '{8'h00, 1'b0, 1'b1, "AAAA"},
    '{8'hFF, 1'b0, 1'b0, 32'h0},
    '{8'hFF, 1'b0, 1'b0, 32'h0},
    '{8'hFF, 1'b1, 1'b1, "////"},
    '{8'h4D, 1'b0, 1'b0, 32'h0},
    '{8'h61, 1'b0, 1'b0, 32'h0},
    '{8'h6E, 1'b1, 1'b1, "TWFu"},
    '{8'h4D, 1'b0, 1'b0, 32'h0},
    '{8'h61, 1'b1, 1'b1, "TWE="},
    '{8'hFB, 1'b0, 1'b0, 32'h0},
    '{8'hFF, 1'b0, 1'b0, 32'h0},
    '{8'hBF, 1'b1, 1'b1, "+/+/"}
  };

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
    err_cnt++;
  endtask

  // encodes one byte into the pending group, returns the number of chars
  function automatic int encode_byte(input logic [b64enc_pkg::ByteW-1:0] b,
                                     input logic eom, output logic [31:0] chars);
    logic [b64enc_pkg::GroupW-1:0] grp;
    int                            nsym;
    chars = '0;
    if (pend_cnt >= b64enc_pkg::CntTwo) begin
      grp  = {pend_bytes, b};
      nsym = 4;
    end else if (!eom) begin
      if (pend_cnt == b64enc_pkg::CntEmpty) begin
        pend_bytes = {b, 8'h00};
      end else begin
        pend_bytes[7:0] = b;
      end
      pend_cnt = pend_cnt + 2'd1;
      return 0;
    end else if (pend_cnt == b64enc_pkg::CntEmpty) begin
      grp  = {b, 16'h0000};
      nsym = 2;
    end else begin
      grp  = {pend_bytes[15:8], b, 8'h00};
      nsym = 3;
    end
    for (int k = 0; k < 4; k++) begin
      chars[31-8*k -: 8] = (k < nsym) ? alphabet[grp[23-6*k -: 6]] : b64enc_pkg::PadChar;
    end
    pend_bytes = '0;
    pend_cnt   = b64enc_pkg::CntEmpty;
    return 4;
  endfunction

  task automatic push_byte(input logic [b64enc_pkg::ByteW-1:0] b, input logic eom,
                           input logic typed, input logic [31:0] typed_chars);
    int          gap;
    int          n;
    logic [31:0] chars;
    gap = tx_idle ? $urandom_range(0, MaxGap) : 0;
    if (gap > 0) begin
      msg_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    msg_if.valid          = 1'b1;
    msg_if.data_byte      = b;
    msg_if.end_of_message = eom;
    do @(posedge clk_i); while (!(msg_if.valid && msg_if.ready));
    n = encode_byte(b, eom, chars);
    if (typed) begin
      chars = typed_chars;
    end
    for (int k = 0; k < n; k++) begin
      char_q.push_back('{chars[31-8*k -: 8], eom && (k == 3)});
    end
    sent_cnt++;
    @(negedge clk_i);
  endtask

  function automatic logic [b64enc_pkg::ByteW-1:0] rand_byte();
    int          sel;
    int unsigned v;
    sel = $urandom_range(0, 7);
    if (sel == 0) begin
      return 8'h00;
    end else if (sel == 1) begin
      return 8'hFF;
    end
    v = $urandom_range(0, 255);
    return v[b64enc_pkg::ByteW-1:0];
  endfunction

  // receiver
  initial begin
    int gap;
    enc_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        enc_if.ready = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
      end
      gap = rx_idle ? $urandom_range(0, MaxGap) : 0;
      if (gap > 0) begin
        enc_if.ready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      enc_if.ready = 1'b1;
      do @(posedge clk_i); while (!(enc_if.valid && enc_if.ready));
    end
  end

  // character checker
  always @(posedge clk_i) begin
    enc_char_t want;
    if (rst_ni && enc_if.valid && enc_if.ready) begin
      if (char_q.size() == 0) begin
        report_mismatch("unexpected char", int'(enc_if.out_char), 0);
      end else begin
        want = char_q.pop_front();
        if (enc_if.out_char !== want.ch) begin
          report_mismatch("out_char", int'(enc_if.out_char), int'(want.ch));
        end
        if (enc_if.final_char !== want.fin) begin
          report_mismatch("final_char", int'(enc_if.final_char), int'(want.fin));
        end
      end
    end
  end

  // stimulus
  initial begin
    int len;
    rst_ni                = 1'b0;
    msg_if.valid          = 1'b0;
    msg_if.data_byte      = '0;
    msg_if.end_of_message = 1'b0;
    pend_bytes            = '0;
    pend_cnt              = b64enc_pkg::CntEmpty;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < DirRows; i++) begin
      push_byte(dir_tab[i].data, dir_tab[i].eom, dir_tab[i].typed, dir_tab[i].chars);
    end

    // long receiver hold while the sender streams without gaps
    tx_idle  = 1'b0;
    rx_idle  = 1'b0;
    hold_req = 1'b1;
    while (sent_cnt < NumItems) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
      if (sent_cnt > DirRows + 30) begin
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle = ($urandom_range(0, 3) != 0);
      end
      for (int j = 0; j < len; j++) begin
        push_byte(rand_byte(), j == len - 1, 1'b0, 32'h0);
      end
    end
    msg_if.valid = 1'b0;

    while (char_q.size() != 0) @(posedge clk_i);
    repeat (DrainCyc) @(posedge clk_i);
    if (err_cnt == 0 && char_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/b64enc_pkg.sv
rtl/core/b64enc_if.sv
rtl/core/b64enc_front.sv
rtl/core/b64enc_queue.sv
rtl/core/b64enc_back.sv
rtl/core/base64_stream_encoder_core.sv
tb/tb_base64_stream_encoder_core.sv
